/* rtl/core/tssd_pkg.sv */
// ----------------------------------------------------------------------------
// tssd_pkg
// Shared types, codes and defaults for the touch slot swipe detector.
// ----------------------------------------------------------------------------
`default_nettype none

package tssd_pkg;

  localparam int unsigned NumSlotsDefault   = 3;
  localparam int unsigned CoordBitsDefault  = 16;
  localparam int unsigned QueueDepthDefault = 2;

  localparam int unsigned ValueW  = 16;
  localparam int unsigned ThreshW = 16;
  localparam int unsigned TrackW  = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 16;

  localparam logic [ThreshW-1:0] ThreshReset = 16'd50;
  localparam logic [TrackW-1:0]  TrackReset  = 2'd2;

  typedef enum logic [1:0] {
    CMD_SLOT  = 2'd0,
    CMD_X     = 2'd1,
    CMD_Y     = 2'd2,
    CMD_OTHER = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KEY_CTRL = 2'd0,
    KEY_PGDN = 2'd1,
    KEY_PGUP = 2'd2
  } key_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD = 1'd0,
    CFG_TRACKED   = 1'd1
  } cfg_e;

  // one queued gesture: which page key the tap uses
  typedef struct packed {
    logic page_up;
  } gest_t;

endpackage

`default_nettype wire

/* rtl/core/tssd_queue.sv */
// ----------------------------------------------------------------------------
// tssd_queue
// Small FIFO of gesture requests between the event front and the key back.
// ----------------------------------------------------------------------------
`default_nettype none

module tssd_queue
  import tssd_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  output logic       push_ready_o,
  input  wire gest_t push_data_i,
  output logic       pop_valid_o,
  input  wire logic  pop_ready_i,
  output gest_t      pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  gest_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tssd_front.sv */
// ----------------------------------------------------------------------------
// tssd_front
// Takes touch events, keeps per-slot positions and the anchor, and classifies
// each event into no gesture, page-down tap or page-up tap.
// ----------------------------------------------------------------------------
`default_nettype none

module tssd_front
  import tssd_pkg::*;
#(
  parameter int unsigned NumSlots  = NumSlotsDefault,
  parameter int unsigned CoordBits = CoordBitsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         cmd_i,
  input  wire logic [ValueW-1:0]  value_i,
  input  wire logic [ThreshW-1:0] threshold_i,
  input  wire logic [TrackW-1:0]  tracked_i,
  output logic                    push_valid_o,
  input  wire logic               push_ready_i,
  output gest_t                   push_data_o
);

  localparam int unsigned SlotW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int unsigned DiffW = ((CoordBits > ThreshW) ? CoordBits : ThreshW) + 2;

  logic [ValueW-1:0]    cur_slot_q, cur_slot_d;
  logic [CoordBits-1:0] x_pos_q [NumSlots];
  logic [CoordBits-1:0] y_pos_q [NumSlots];
  logic [NumSlots-1:0]  x_known_q, y_known_q;
  logic [CoordBits-1:0] anchor_x_q, anchor_y_q;
  logic                 anchor_known_q, armed_q;

  logic                 fire, slot_ok, track_hit;
  logic                 x_wr, y_wr, x_fwd, y_fwd, xk, yk, check;
  logic [SlotW-1:0]     cur_idx, ts_idx;
  logic [CoordBits-1:0] coord, cx, cy;
  logic signed [DiffW-1:0] dx, dy, thr;
  logic                 fwd, bwd;
  logic                 set_anchor, set_armed;

  assign in_ready_o = push_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  assign cur_idx  = cur_slot_q[SlotW-1:0];
  assign ts_idx   = SlotW'(tracked_i);
  assign slot_ok  = (cur_slot_q < ValueW'(NumSlots));
  assign coord    = CoordBits'(value_i);

  assign x_wr = (cmd_i == CMD_X) && slot_ok;
  assign y_wr = (cmd_i == CMD_Y) && slot_ok;
  assign cur_slot_d = (cmd_i == CMD_SLOT) ? value_i : cur_slot_q;

  // forward this event's own write to the tracked-slot check
  assign x_fwd = x_wr && (cur_idx == ts_idx);
  assign y_fwd = y_wr && (cur_idx == ts_idx);
  assign xk    = x_known_q[ts_idx] || x_fwd;
  assign yk    = y_known_q[ts_idx] || y_fwd;
  assign cx    = x_fwd ? coord : x_pos_q[ts_idx];
  assign cy    = y_fwd ? coord : y_pos_q[ts_idx];

  assign track_hit = (ValueW'(tracked_i) < ValueW'(NumSlots))
                  && (cur_slot_d == ValueW'(tracked_i));
  assign check     = fire && track_hit && xk && yk;

  assign dx  = $signed(DiffW'(cx)) - $signed(DiffW'(anchor_x_q));
  assign dy  = $signed(DiffW'(cy)) - $signed(DiffW'(anchor_y_q));
  assign thr = $signed(DiffW'(threshold_i));
  assign fwd = (dx > thr) && (dy > thr);
  assign bwd = (dx < -thr) && (dy < -thr);

  always_comb begin
    set_anchor   = 1'b0;
    set_armed    = 1'b0;
    push_valid_o = 1'b0;
    push_data_o  = '{page_up: 1'b0};
    if (check) begin
      if (!anchor_known_q) begin
        set_anchor = 1'b1;
      end else if (fwd) begin
        set_anchor   = 1'b1;
        push_valid_o = 1'b1;
      end else if (bwd) begin
        if (!armed_q) begin
          set_armed = 1'b1;   // first backward swipe is swallowed
        end else begin
          set_anchor   = 1'b1;
          push_valid_o = 1'b1;
          push_data_o  = '{page_up: 1'b1};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_slot_q     <= '0;
      x_known_q      <= '0;
      y_known_q      <= '0;
      anchor_known_q <= 1'b0;
      armed_q        <= 1'b0;
    end else if (fire) begin
      cur_slot_q <= cur_slot_d;
      if (x_wr) begin
        x_known_q[cur_idx] <= 1'b1;
      end
      if (y_wr) begin
        y_known_q[cur_idx] <= 1'b1;
      end
      if (set_anchor) begin
        anchor_known_q <= 1'b1;
      end
      if (set_armed) begin
        armed_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && x_wr) begin
      x_pos_q[cur_idx] <= coord;
    end
    if (fire && y_wr) begin
      y_pos_q[cur_idx] <= coord;
    end
    if (set_anchor) begin
      anchor_x_q <= cx;
      anchor_y_q <= cy;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tssd_back.sv */
// ----------------------------------------------------------------------------
// tssd_back
// Plays one queued gesture out as four key events: ctrl press, page press,
// page release, ctrl release.
// ----------------------------------------------------------------------------
`default_nettype none

module tssd_back
  import tssd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  pop_valid_i,
  output logic       pop_ready_o,
  input  wire gest_t pop_data_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output logic [1:0] key_code_o,
  output logic       pressed_o,
  output logic       last_event_o
);

  logic       busy_q, busy_d;
  logic [1:0] beat_q, beat_d;
  logic       page_up_q;
  logic       out_fire, done;

  assign out_fire    = busy_q && out_ready_i;
  assign done        = out_fire && (beat_q == 2'd3);
  assign pop_ready_o = !busy_q || done;

  always_comb begin
    busy_d = busy_q;
    beat_d = beat_q;
    if (out_fire) begin
      beat_d = beat_q + 1'b1;
    end
    if (pop_ready_o) begin
      busy_d = pop_valid_i;
      beat_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      beat_q <= '0;
    end else begin
      busy_q <= busy_d;
      beat_q <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_ready_o && pop_valid_i) begin
      page_up_q <= pop_data_i.page_up;
    end
  end

  always_comb begin
    case (beat_q)
      2'd1, 2'd2: key_code_o = page_up_q ? KEY_PGUP : KEY_PGDN;
      default:    key_code_o = KEY_CTRL;
    endcase
  end

  assign out_valid_o  = busy_q;
  assign pressed_o    = (beat_q == 2'd0) || (beat_q == 2'd1);
  assign last_event_o = (beat_q == 2'd3);

endmodule

`default_nettype wire

/* rtl/core/touch_slot_swipe_detector.sv */
// Flow: a gesture's first key event shows on the outputs after it has passed
//   the queue and the key player's busy register; the other three follow one
//   per cycle while out_ready_i is high.
// Rates: one touch event per cycle while the gesture queue has room; the key
//   player sends four key events per gesture; a 2-entry queue absorbs the gap.
// Reset: asynchronous, active low; clears slot marks, anchor and queue state.
// ----------------------------------------------------------------------------
// touch_slot_swipe_detector
// Turns two-axis swipes of one touch slot into ctrl+page-up/down key taps.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_slot_swipe_detector
  import tssd_pkg::*;
#(
  parameter int unsigned NumSlots   = NumSlotsDefault,
  parameter int unsigned CoordBits  = CoordBitsDefault,
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         cmd_i,
  input  wire logic [ValueW-1:0]  value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              key_code_o,
  output logic                    pressed_o,
  output logic                    last_event_o
);

  logic [ThreshW-1:0] threshold_q;
  logic [TrackW-1:0]  tracked_q;

  logic  push_valid, push_ready, pop_valid, pop_ready;
  gest_t push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThreshReset;
      tracked_q   <= TrackReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_THRESHOLD: threshold_q <= cfg_wdata_i[ThreshW-1:0];
        CFG_TRACKED:   tracked_q   <= cfg_wdata_i[TrackW-1:0];
        default: ;
      endcase
    end
  end

  tssd_front #(
    .NumSlots  (NumSlots),
    .CoordBits (CoordBits)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .value_i      (value_i),
    .threshold_i  (threshold_q),
    .tracked_i    (tracked_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  tssd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  tssd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_data_i   (pop_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .key_code_o   (key_code_o),
    .pressed_o    (pressed_o),
    .last_event_o (last_event_o)
  );

endmodule

`default_nettype wire

/* rtl/core/tssd_checker.sv */
// ----------------------------------------------------------------------------
// tssd_checker
// Port-level checks on the key event stream of the swipe detector.
// ----------------------------------------------------------------------------
`default_nettype none

module tssd_checker
  import tssd_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [1:0] key_code_o,
  input wire logic       pressed_o,
  input wire logic       last_event_o
);

  logic out_fire;
  assign out_fire = out_valid_o && out_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(key_code_o)
      && $stable(pressed_o) && $stable(last_event_o))
    else $error("key request dropped or changed while stalled");

  a_last_is_ctrl_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_event_o |-> key_code_o == KEY_CTRL && !pressed_o)
    else $error("last key event is not a ctrl release");

  a_ctrl_then_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && key_code_o == KEY_CTRL && pressed_o |=>
      out_valid_o && key_code_o != KEY_CTRL && pressed_o)
    else $error("ctrl press not followed by a page key press");

  a_tap_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !last_event_o |=> out_valid_o)
    else $error("key tap sequence broken off");

endmodule

bind touch_slot_swipe_detector tssd_checker u_tssd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .key_code_o   (key_code_o),
  .pressed_o    (pressed_o),
  .last_event_o (last_event_o)
);

`default_nettype wire
